// ===== sv/mlpbp_pkg.sv =====
// Shared constants, types and sigmoid table for the online perceptron trainer.
package mlpbp_pkg;

  localparam int NUM_INPUTS = 2;
  localparam int NUM_HIDDEN = 2;
  localparam int SIG_DEPTH  = 256;
  localparam int SIG_IDX_W  = $clog2(SIG_DEPTH);

  localparam int ONE_Q12 = 4096;
  localparam int W_W     = 18;
  localparam int ACC_W   = 40;
  localparam int IDX_W   = 4;

  typedef enum logic [1:0] {
    OP_TRAIN = 2'd0,
    OP_INFER = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // One strobe per sequencer step, plus load enables.
  typedef struct packed {
    logic                  hid;
    logic                  hsig;
    logic                  osum;
    logic                  ysig;
    logic                  err;
    logic                  del;
    logic                  b1;
    logic                  b2;
    logic                  b3;
    logic                  b4;
    logic                  b5;
    logic                  b6;
    logic [NUM_INPUTS-1:0] ld_w;
    logic                  ld_b;
    logic                  ld_wo;
    logic                  ld_bo;
  } step_t;

  typedef logic [12:0] sig_table_t [SIG_DEPTH];

  // Shift-subtract quotient, used only while the table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-num/SIG_DEPTH) in Q31, Taylor series on a/16 then squared four times.
  function automatic logic [63:0] exp_neg_q31(input logic [63:0] num);
    logic [63:0] a;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] sum;
    a    = (num << 31) >> SIG_IDX_W;
    t    = a >> 4;
    term = 64'd1 << 31;
    sum  = term;
    for (int k = 1; k <= 14; k++) begin
      term = udiv64((term * t) >> 31, 64'(k));
      if ((k & 1) == 1) sum = sum - term;
      else sum = sum + term;
    end
    for (int k = 0; k < 4; k++) begin
      sum = (sum * sum) >> 31;
    end
    return sum;
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t  tab;
    logic [63:0] p;
    logic [63:0] num;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] n;
    logic [63:0] s;
    logic        neg;
    for (int k = 0; k < SIG_DEPTH; k++) begin
      p   = 64'(2 * k + 1);
      neg = (p < 64'(SIG_DEPTH));
      num = neg ? 64'd8 * (64'(SIG_DEPTH) - p) : 64'd8 * (p - 64'(SIG_DEPTH));
      e   = exp_neg_q31(num);
      den = (64'd1 << 31) + e;
      n   = neg ? 64'(ONE_Q12) * e : 64'(ONE_Q12) << 31;
      s   = udiv64(n + (den >> 1), den);
      if (s > 64'(ONE_Q12)) s = 64'(ONE_Q12);
      tab[k] = s[12:0];
    end
    return tab;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

  function automatic logic [12:0] sig_f(input logic signed [ACC_W-1:0] z);
    logic signed [15:0] zc;
    logic [15:0]        u;
    if (z < -32768) zc = 16'sh8000;
    else if (z > 32767) zc = 16'sh7fff;
    else zc = z[15:0];
    u = {~zc[15], zc[14:0]};
    return SIG_TABLE[u[15 -: SIG_IDX_W]];
  endfunction

  function automatic logic signed [W_W-1:0] sat_w(input logic signed [ACC_W-1:0] v);
    if (v > 131071) return 18'sh1ffff;
    if (v < -131072) return 18'sh20000;
    return v[W_W-1:0];
  endfunction

endpackage

// ===== sv/mlpbp_lane.sv =====
// One hidden unit: its weights, forward activation and backward update.
module mlpbp_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mlpbp_pkg::step_t     step_i,
  input  logic signed [17:0]   x_i [mlpbp_pkg::NUM_INPUTS],
  input  logic signed [17:0]   ld_val_i,
  input  logic [15:0]          alpha_i,
  input  logic signed [13:0]   delta_i,
  input  logic signed [30:0]   ad_i,
  output logic [12:0]          h_o,
  output logic signed [17:0]   wo_o
);

  localparam int AW = mlpbp_pkg::ACC_W;

  logic signed [17:0]   w_q [mlpbp_pkg::NUM_INPUTS];
  logic signed [17:0]   w_d [mlpbp_pkg::NUM_INPUTS];
  logic signed [17:0]   b_q, b_d, wo_q, wo_d;
  logic signed [AW-1:0] hacc_q, hacc_d;
  logic [12:0]          h_q;
  logic [23:0]          hh_q, hh_d;
  logic signed [44:0]   ahd_q, ahd_d;
  logic signed [38:0]   p2_q, p2_d;
  logic signed [56:0]   p3_q, p3_d;
  logic signed [20:0]   md_q;
  logic signed [37:0]   amd_q, amd_d;
  logic signed [35:0]   xw;
  logic signed [55:0]   dw;
  logic signed [AW-1:0] acc;

  always_comb begin
    acc = AW'(b_q);
    acc = -(acc <<< 12);
    for (int j = 0; j < mlpbp_pkg::NUM_INPUTS; j++) begin
      xw  = x_i[j] * w_q[j];
      acc = acc + AW'(xw);
    end
    hacc_d = acc;
    hh_d   = 24'(h_q) * (24'(mlpbp_pkg::ONE_Q12) - 24'(h_q));
    ahd_d  = ad_i * $signed({1'b0, h_q});
    p2_d   = $signed({1'b0, hh_q}) * delta_i;
    p3_d   = p2_q * wo_q;
    amd_d  = $signed({1'b0, alpha_i}) * md_q;
  end

  always_comb begin
    for (int j = 0; j < mlpbp_pkg::NUM_INPUTS; j++) begin
      dw     = amd_q * x_i[j];
      w_d[j] = w_q[j];
      if (step_i.ld_w[j]) w_d[j] = ld_val_i;
      else if (step_i.b6) w_d[j] = mlpbp_pkg::sat_w(AW'(w_q[j]) + AW'(dw >>> 24));
    end
    b_d = b_q;
    if (step_i.ld_b) b_d = ld_val_i;
    else if (step_i.b6) b_d = mlpbp_pkg::sat_w(AW'(b_q) + ((-AW'(amd_q)) >>> 12));
    wo_d = wo_q;
    if (step_i.ld_wo) wo_d = ld_val_i;
    // the hidden delta reads the old output weight, taken in the same step
    else if (step_i.b3) wo_d = mlpbp_pkg::sat_w(AW'(wo_q) + AW'(ahd_q >>> 24));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < mlpbp_pkg::NUM_INPUTS; j++) w_q[j] <= '0;
      b_q  <= '0;
      wo_q <= '0;
    end else begin
      for (int j = 0; j < mlpbp_pkg::NUM_INPUTS; j++) w_q[j] <= w_d[j];
      b_q  <= b_d;
      wo_q <= wo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.hid)  hacc_q <= hacc_d;
    if (step_i.hsig) h_q    <= mlpbp_pkg::sig_f(hacc_q >>> 12);
    if (step_i.b1)   hh_q   <= hh_d;
    if (step_i.b2) begin
      ahd_q <= ahd_d;
      p2_q  <= p2_d;
    end
    if (step_i.b3)   p3_q   <= p3_d;
    if (step_i.b4)   md_q   <= 21'(p3_q >>> 36);
    if (step_i.b5)   amd_q  <= amd_d;
  end

  assign h_o  = h_q;
  assign wo_o = wo_q;

endmodule

// ===== sv/mlpbp_merge.sv =====
// Output unit: combines the hidden lanes, forms y, the error and the delta.
module mlpbp_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mlpbp_pkg::step_t     step_i,
  input  logic [12:0]          h_i  [mlpbp_pkg::NUM_HIDDEN],
  input  logic signed [17:0]   wo_i [mlpbp_pkg::NUM_HIDDEN],
  input  logic [12:0]          tgt_i,
  input  logic [15:0]          alpha_i,
  input  logic signed [17:0]   ld_val_i,
  output logic [12:0]          y_o,
  output logic [12:0]          sq_o,
  output logic signed [13:0]   delta_o,
  output logic signed [30:0]   ad_o
);

  localparam int AW = mlpbp_pkg::ACC_W;

  logic signed [17:0]   bo_q, bo_d;
  logic signed [AW-1:0] oacc_q, oacc_d;
  logic [12:0]          y_q, sq_q, tc;
  logic signed [13:0]   e_d;
  logic signed [27:0]   ey_q, ey_d, ee;
  logic signed [41:0]   dp;
  logic signed [13:0]   delta_q;
  logic signed [30:0]   ad_q, ad_d;
  logic signed [30:0]   hw;

  always_comb begin
    oacc_d = AW'(bo_q);
    oacc_d = -(oacc_d <<< 12);
    for (int i = 0; i < mlpbp_pkg::NUM_HIDDEN; i++) begin
      hw     = $signed({1'b0, h_i[i]}) * wo_i[i];
      oacc_d = oacc_d + AW'(hw);
    end
    // clamp a target above one
    tc   = (tgt_i > 13'(mlpbp_pkg::ONE_Q12)) ? 13'(mlpbp_pkg::ONE_Q12) : tgt_i;
    e_d  = $signed({1'b0, tc}) - $signed({1'b0, y_q});
    ey_d = e_d * $signed({1'b0, y_q});
    ee   = e_d * e_d;
    dp   = ey_q * $signed({1'b0, 13'(mlpbp_pkg::ONE_Q12) - y_q});
    ad_d = $signed({1'b0, alpha_i}) * delta_q;
    bo_d = bo_q;
    if (step_i.ld_bo) bo_d = ld_val_i;
    else if (step_i.b2) bo_d = mlpbp_pkg::sat_w(AW'(bo_q) + ((-AW'(ad_q)) >>> 12));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bo_q <= '0;
    end else begin
      bo_q <= bo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.osum) oacc_q <= oacc_d;
    if (step_i.ysig) y_q    <= mlpbp_pkg::sig_f(oacc_q >>> 12);
    if (step_i.err) begin
      ey_q <= ey_d;
      sq_q <= ee[24:12];
    end
    if (step_i.del) delta_q <= 14'(dp >>> 24);
    if (step_i.b1)  ad_q    <= ad_d;
  end

  assign y_o     = y_q;
  assign sq_o    = sq_q;
  assign delta_o = delta_q;
  assign ad_o    = ad_q;

endmodule

// ===== sv/mlp_backprop_online_trainer_unit.sv =====
// Top level: request sequencer, hidden lanes and output merge of the trainer.
//
//   port group     dir   handshake               carries
//   input request  in    in_valid_i/in_stall_o   opcode, x0, x1, target, weight index/value
//   result         out   out_valid_o/out_stall_i y, sq_error
//   config write   in    cfg_valid_i/cfg_ready_o learning rate (Q4.12)
//
// Train runs S_HID, S_HSIG, S_OSUM, S_YSIG, S_ERR, S_DEL and S_B1 to S_B6, infer ends after
// S_YSIG, load runs S_LOAD, an unused opcode goes to S_DONE; the chain of dependent multiplies
// through the forward pass, output delta and hidden deltas sets this, one multiply stage per cycle.
// One request is in flight at a time; a waiting result does not block the next accept.
// Reset clears all weights and biases to zero and sets the learning rate to 1.0.
// A stalled result holds until taken; the final step waits for the output register.
module mlp_backprop_online_trainer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [17:0] x0_i,
  input  logic signed [17:0] x1_i,
  input  logic [12:0]        target_i,
  input  logic [3:0]         weight_index_i,
  input  logic signed [17:0] weight_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [12:0]        y_o,
  output logic [12:0]        sq_error_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);

  localparam int NI = mlpbp_pkg::NUM_INPUTS;
  localparam int NH = mlpbp_pkg::NUM_HIDDEN;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_HID, S_HSIG, S_OSUM, S_YSIG, S_ERR, S_DEL,
    S_B1, S_B2, S_B3, S_B4, S_B5, S_B6, S_DONE
  } state_e;

  state_e             state_q;
  mlpbp_pkg::op_e     op_q;
  logic signed [17:0] x_q [NI];
  logic [12:0]        tgt_q;
  logic [3:0]         idx_q;
  logic signed [17:0] val_q;
  logic [15:0]        alpha_q;
  logic               out_valid_q;
  logic [12:0]        y_q, sq_q;
  logic               accept;

  mlpbp_pkg::step_t   step;
  mlpbp_pkg::step_t   lane_step [NH];
  logic [12:0]        h_w  [NH];
  logic signed [17:0] wo_w [NH];
  logic [12:0]        y_w, sq_w;
  logic signed [13:0] delta_w;
  logic signed [30:0] ad_w;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    step      = '0;
    step.hid  = (state_q == S_HID);
    step.hsig = (state_q == S_HSIG);
    step.osum = (state_q == S_OSUM);
    step.ysig = (state_q == S_YSIG);
    step.err  = (state_q == S_ERR);
    step.del  = (state_q == S_DEL);
    step.b1   = (state_q == S_B1);
    step.b2   = (state_q == S_B2);
    step.b3   = (state_q == S_B3);
    step.b4   = (state_q == S_B4);
    step.b5   = (state_q == S_B5);
    step.b6   = (state_q == S_B6);
    step.ld_bo = (state_q == S_LOAD) &&
                 (idx_q == mlpbp_pkg::IDX_W'(NH * NI + 2 * NH));
  end

  // decode the load index onto each lane
  always_comb begin
    for (int i = 0; i < NH; i++) begin
      lane_step[i]       = step;
      lane_step[i].ld_bo = 1'b0;
      for (int j = 0; j < NI; j++) begin
        lane_step[i].ld_w[j] = (state_q == S_LOAD) &&
                               (idx_q == mlpbp_pkg::IDX_W'(i * NI + j));
      end
      lane_step[i].ld_b  = (state_q == S_LOAD) &&
                           (idx_q == mlpbp_pkg::IDX_W'(NH * NI + i));
      lane_step[i].ld_wo = (state_q == S_LOAD) &&
                           (idx_q == mlpbp_pkg::IDX_W'(NH * NI + NH + i));
    end
  end

  for (genvar i = 0; i < NH; i++) begin : g_lane
    mlpbp_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .step_i   (lane_step[i]),
      .x_i      (x_q),
      .ld_val_i (val_q),
      .alpha_i  (alpha_q),
      .delta_i  (delta_w),
      .ad_i     (ad_w),
      .h_o      (h_w[i]),
      .wo_o     (wo_w[i])
    );
  end

  mlpbp_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .h_i      (h_w),
    .wo_i     (wo_w),
    .tgt_i    (tgt_q),
    .alpha_i  (alpha_q),
    .ld_val_i (val_q),
    .y_o      (y_w),
    .sq_o     (sq_w),
    .delta_o  (delta_w),
    .ad_o     (ad_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 16'(mlpbp_pkg::ONE_Q12);
    end else if (cfg_valid_i && cfg_ready_o) begin
      alpha_q <= cfg_data_i;
    end
  end

  // hold the request fields for the whole sequence
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= mlpbp_pkg::op_e'(opcode_i);
      x_q[0] <= x0_i;
      for (int j = 1; j < NI; j++) x_q[j] <= (j == 1) ? x1_i : '0;
      tgt_q  <= target_i;
      idx_q  <= weight_index_i;
      val_q  <= weight_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      y_q         <= '0;
      sq_q        <= '0;
    end else begin
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (mlpbp_pkg::op_e'(opcode_i))
              mlpbp_pkg::OP_LOAD:                     state_q <= S_LOAD;
              mlpbp_pkg::OP_NONE:                     state_q <= S_DONE;
              mlpbp_pkg::OP_TRAIN, mlpbp_pkg::OP_INFER: state_q <= S_HID;
              default:                                state_q <= S_DONE;
            endcase
          end
        end
        S_LOAD: state_q <= S_DONE;
        S_HID:  state_q <= S_HSIG;
        S_HSIG: state_q <= S_OSUM;
        S_OSUM: state_q <= S_YSIG;
        S_YSIG: state_q <= (op_q == mlpbp_pkg::OP_TRAIN) ? S_ERR : S_DONE;
        S_ERR:  state_q <= S_DEL;
        S_DEL:  state_q <= S_B1;
        S_B1:   state_q <= S_B2;
        S_B2:   state_q <= S_B3;
        S_B3:   state_q <= S_B4;
        S_B4:   state_q <= S_B5;
        S_B5:   state_q <= S_B6;
        S_B6:   state_q <= S_DONE;
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            y_q  <= (op_q == mlpbp_pkg::OP_TRAIN || op_q == mlpbp_pkg::OP_INFER) ?
                    y_w : '0;
            sq_q <= (op_q == mlpbp_pkg::OP_TRAIN) ? sq_w : '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign y_o         = y_q;
  assign sq_error_o  = sq_q;

endmodule

// ===== sv/mlpbp_checker.sv =====
// Port-level checks for the trainer, bound to the top level.
module mlpbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [12:0] y_o,
  input logic [12:0] sq_error_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(y_o) && $stable(sq_error_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while a sequence was starting");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in flight");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> y_o <= 13'd4096 && sq_error_o <= 13'd4096)
    else $error("result above one");

endmodule

bind mlp_backprop_online_trainer_unit mlpbp_checker u_mlpbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .y_o         (y_o),
  .sq_error_o  (sq_error_o)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the online-trained two-layer sigmoid perceptron.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    mlpbp_pkg::op_e     op;
    logic signed [17:0] x0;
    logic signed [17:0] x1;
    logic [12:0]        tgt;
    logic [3:0]         widx;
    logic signed [17:0] wval;
  } req_t;

  typedef struct {
    logic [12:0] y;
    logic [12:0] sq;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         opcode = mlpbp_pkg::OP_NONE;
  logic signed [17:0] x0 = '0;
  logic signed [17:0] x1 = '0;
  logic [12:0]        target = '0;
  logic [3:0]         widx = '0;
  logic signed [17:0] wval = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [12:0]        y_out;
  logic [12:0]        sq_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_data = '0;

  mlp_backprop_online_trainer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .x0_i          (x0),
    .x1_i          (x1),
    .target_i      (target),
    .weight_index_i(widx),
    .weight_value_i(wval),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .y_o           (y_out),
    .sq_error_o    (sq_out),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  req_t pending_reqs[$];
  res_t expected_out[$];
  int   errors = 0;
  int   quiet_cycles = 0;
  bit   calm = 1'b0;

  // network state mirror
  logic [12:0] sig_tab [256];
  longint      hw [4];
  longint      hb [2];
  longint      wo [2];
  longint      ob;
  longint      alpha;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned exp_neg(longint unsigned num);
    longint unsigned a, t, term, sum;
    a    = (num << 31) / 256;
    t    = a >> 4;
    term = 64'd1 << 31;
    sum  = term;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * t) >> 31) / longint'(k);
      if (k & 1) sum -= term;
      else sum += term;
    end
    for (int k = 0; k < 4; k++) sum = (sum * sum) >> 31;
    return sum;
  endfunction

  task automatic fill_sig_tab();
    longint unsigned p, num, e, den, n, s;
    bit neg;
    for (int k = 0; k < 256; k++) begin
      p   = 2 * k + 1;
      neg = p < 256;
      num = neg ? 8 * (256 - p) : 8 * (p - 256);
      e   = exp_neg(num);
      den = (64'd1 << 31) + e;
      n   = neg ? 4096 * e : 64'd4096 << 31;
      s   = (n + den / 2) / den;
      if (s > 4096) s = 4096;
      sig_tab[k] = s[12:0];
    end
  endtask

  function automatic longint sig_lookup(longint z);
    if (z < -32768) z = -32768;
    if (z > 32767) z = 32767;
    return longint'(sig_tab[(z + 32768) >>> 8]);
  endfunction

  function automatic longint clip18(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  // Mirror one request on the network state and queue its result.
  task automatic train_step(req_t r);
    longint x[2], h[2], wo_old[2];
    longint acc, y, e, dl, md, tgt;
    res_t res;
    res.y  = '0;
    res.sq = '0;
    if (r.op == mlpbp_pkg::OP_LOAD) begin
      if (r.widx < 4) hw[r.widx] = r.wval;
      else if (r.widx < 6) hb[r.widx - 4] = r.wval;
      else if (r.widx < 8) wo[r.widx - 6] = r.wval;
      else if (r.widx == 8) ob = r.wval;
    end else if (r.op != mlpbp_pkg::OP_NONE) begin
      x[0] = r.x0;
      x[1] = r.x1;
      for (int i = 0; i < 2; i++) begin
        acc  = -(hb[i] * 4096) + x[0] * hw[2 * i] + x[1] * hw[2 * i + 1];
        h[i] = sig_lookup(acc >>> 12);
      end
      acc   = -(ob * 4096) + h[0] * wo[0] + h[1] * wo[1];
      y     = sig_lookup(acc >>> 12);
      res.y = y[12:0];
      if (r.op == mlpbp_pkg::OP_TRAIN) begin
        tgt = r.tgt;
        if (tgt > 4096) tgt = 4096;
        e  = tgt - y;
        acc = (e * e) >>> 12;
        res.sq = acc[12:0];
        dl = (e * y * (4096 - y)) >>> 24;
        for (int i = 0; i < 2; i++) begin
          wo_old[i] = wo[i];
          wo[i] = clip18(wo[i] + ((alpha * h[i] * dl) >>> 24));
        end
        ob = clip18(ob + ((-(alpha * dl)) >>> 12));
        for (int i = 0; i < 2; i++) begin
          md = (h[i] * (4096 - h[i]) * wo_old[i] * dl) >>> 36;
          for (int j = 0; j < 2; j++)
            hw[2 * i + j] = clip18(hw[2 * i + j] + ((alpha * x[j] * md) >>> 24));
          hb[i] = clip18(hb[i] + ((-(alpha * md)) >>> 12));
        end
      end
    end
    expected_out.push_back(res);
  endtask

  // Driver: present queued requests, idle at random between them unless calm is set.
  always @(posedge clk_i) begin
    req_t r;
    bit   take;
    if (rst_ni) begin
      take = !in_valid;
      if (in_valid && !in_stall) begin
        r.op   = mlpbp_pkg::op_e'(opcode);
        r.x0   = x0;
        r.x1   = x1;
        r.tgt  = target;
        r.widx = widx;
        r.wval = wval;
        train_step(r);
        take = 1'b1;
      end
      if (take) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
          r = pending_reqs.pop_front();
          opcode   <= r.op;
          x0       <= r.x0;
          x1       <= r.x1;
          target   <= r.tgt;
          widx     <= r.widx;
          wval     <= r.wval;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take results against the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_out.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result y=%0d sq=%0d", y_out, sq_out);
        end else begin
          want = expected_out.pop_front();
          if (want.y !== y_out || want.sq !== sq_out) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: y exp %0d got %0d, sq exp %0d got %0d",
                       want.y, y_out, want.sq, sq_out);
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 24);
    end
  end

  // Watchdog: count cycles with no handshake at all.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 3000) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic logic signed [17:0] rnd_w();
    if ($urandom_range(3) == 0) return 18'($urandom);
    return 18'(int'($urandom_range(32768)) - 16384);
  endfunction

  task automatic add_req(mlpbp_pkg::op_e op, int a, int b, int t, int i, int v);
    req_t r;
    r.op   = op;
    r.x0   = 18'(a);
    r.x1   = 18'(b);
    r.tgt  = 13'(t);
    r.widx = 4'(i);
    r.wval = 18'(v);
    pending_reqs.push_back(r);
  endtask

  task automatic add_random(int n);
    int             k;
    mlpbp_pkg::op_e op;
    for (int c = 0; c < n; c++) begin
      k = $urandom_range(99);
      if (k < 60) op = mlpbp_pkg::OP_TRAIN;
      else if (k < 75) op = mlpbp_pkg::OP_INFER;
      else if (k < 95) op = mlpbp_pkg::OP_LOAD;
      else op = mlpbp_pkg::OP_NONE;
      add_req(op, rnd_w(), rnd_w(),
              $urandom_range(4) == 0 ? $urandom_range(8191) : $urandom_range(4096),
              $urandom_range(99) < 90 ? $urandom_range(8) : $urandom_range(15),
              rnd_w());
    end
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid || expected_out.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [15:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i);
    while (!cfg_ready);
    alpha = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    fill_sig_tab();
    foreach (hw[i]) hw[i] = 0;
    hb = '{0, 0};
    wo = '{0, 0};
    ob = 0;
    alpha = 4096;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero network, loads at the extremes, ignored codes, clamped target
    add_req(mlpbp_pkg::OP_TRAIN, 131071, -131072, 4096, 0, 0);
    add_req(mlpbp_pkg::OP_INFER, -131072, 131071, 0, 0, 0);
    add_req(mlpbp_pkg::OP_LOAD, 0, 0, 0, 0, 131071);
    add_req(mlpbp_pkg::OP_LOAD, 0, 0, 0, 1, -131072);
    add_req(mlpbp_pkg::OP_LOAD, 0, 0, 0, 2, 4096);
    add_req(mlpbp_pkg::OP_LOAD, 0, 0, 0, 3, -4096);
    add_req(mlpbp_pkg::OP_LOAD, 0, 0, 0, 4, 2048);
    add_req(mlpbp_pkg::OP_LOAD, 0, 0, 0, 5, -2048);
    add_req(mlpbp_pkg::OP_LOAD, 0, 0, 0, 6, 8192);
    add_req(mlpbp_pkg::OP_LOAD, 0, 0, 0, 7, -8192);
    add_req(mlpbp_pkg::OP_LOAD, 0, 0, 0, 8, 1000);
    add_req(mlpbp_pkg::OP_LOAD, 0, 0, 0, 9, 5555);
    add_req(mlpbp_pkg::OP_LOAD, 0, 0, 0, 15, -5555);
    add_req(mlpbp_pkg::OP_NONE, 131071, 131071, 8191, 15, 131071);
    add_req(mlpbp_pkg::OP_INFER, 4096, -4096, 0, 0, 0);
    add_req(mlpbp_pkg::OP_TRAIN, 4096, 4096, 8191, 0, 0);
    add_req(mlpbp_pkg::OP_TRAIN, -4096, 4096, 0, 0, 0);
    add_req(mlpbp_pkg::OP_TRAIN, 131071, 131071, 4096, 0, 0);
    add_req(mlpbp_pkg::OP_TRAIN, -131072, -131072, 0, 0, 0);
    add_req(mlpbp_pkg::OP_TRAIN, 0, 0, 2048, 0, 0);
    add_req(mlpbp_pkg::OP_INFER, 1, -1, 0, 0, 0);
    drain();

    write_rate(16'd0);
    add_random(140);
    drain();
    write_rate(16'hffff);
    add_random(170);
    drain();
    // a stretch with no idling on either side
    calm = 1'b1;
    write_rate(16'($urandom));
    add_random(180);
    drain();
    calm = 1'b0;
    write_rate(16'd1);
    add_random(160);
    drain();
    write_rate(16'd4096);
    add_random(180);
    drain();

    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
